// ===== hdl/wheel_speed_limiter_assert.svh =====
// ----------------------------------------------------------------------------
// Wheel speed limiter assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_LIMITER_ASSERT_SVH
`define WHEEL_SPEED_LIMITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under active-low reset.
`define WSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsl: same-cycle check failed");
// Next-cycle implication under active-low reset.
`define WSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsl: next-cycle check failed");
`else
`define WSL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WSL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/wsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Wheel speed limiter package
// Field widths, register codes, reset values and controller states.
// ----------------------------------------------------------------------------
package wsl_pkg;

    localparam int SPEED_WIDTH_DEF = 24;
    localparam int DIAM_W          = 16;
    localparam int LIMIT_W         = 20;
    localparam int TIME_W          = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 20;
    // speed limit is compared against 2 * 4096 * max_linear_speed
    localparam int NUM_SHIFT       = 13;
    localparam int NUM_W           = LIMIT_W + NUM_SHIFT;
    localparam int BUD_W           = LIMIT_W + TIME_W;

    localparam logic [DIAM_W-1:0]  DIAM_RST  = 16'd1353;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 20'd4096;
    localparam logic [LIMIT_W-1:0] ACCEL_RST = 20'd20480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHEEL_DIAMETER   = 2'd0,
        CFG_MAX_LINEAR_SPEED = 2'd1,
        CFG_MAX_ACCELERATION = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_MUL,
        S_CMP,
        S_DIV,
        S_DELTA,
        S_SLEW
    } t_state;

endpackage

// ===== hdl/wsl_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Wheel command channel
// Valid/ready channel carrying both wheel commands and the step time.
// ----------------------------------------------------------------------------
interface wsl_cmd_if #(
    parameter int SPEED_WIDTH = wsl_pkg::SPEED_WIDTH_DEF
);
    import wsl_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SPEED_WIDTH-1:0] left_command;
    logic signed [SPEED_WIDTH-1:0] right_command;
    logic [TIME_W-1:0]             step_time;

    modport source (output valid, left_command, right_command, step_time, input ready);
    modport sink   (input valid, left_command, right_command, step_time, output ready);

endinterface

// ===== hdl/wsl_spd_if.sv =====
// ----------------------------------------------------------------------------
// Wheel speed channel
// Valid/ready channel carrying the two limited wheel speeds.
// ----------------------------------------------------------------------------
interface wsl_spd_if #(
    parameter int SPEED_WIDTH = wsl_pkg::SPEED_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SPEED_WIDTH-1:0] left_speed;
    logic signed [SPEED_WIDTH-1:0] right_speed;

    modport source (output valid, left_speed, right_speed, input ready);
    modport sink   (input valid, left_speed, right_speed, output ready);

endinterface

// ===== hdl/wsl_smul.sv =====
// ----------------------------------------------------------------------------
// Wheel speed limiter serial multiplier
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module wsl_smul #(
    parameter int AW = wsl_pkg::SPEED_WIDTH_DEF,
    parameter int BW = wsl_pkg::DIAM_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_product
);
    localparam int PW    = AW + BW;
    localparam int CNT_W = $clog2(BW);

    logic [PW-1:0]    r_acc;
    logic [PW-1:0]    n_acc;
    logic [AW-1:0]    r_a;
    logic [BW-1:0]    r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             n_done;

    // double the partial sum, add the multiplicand for a set bit
    assign n_acc  = {r_acc[PW-2:0], 1'b0} + (r_b[BW-1] ? PW'(r_a) : '0);
    assign n_done = r_busy && (r_cnt == '0) && !i_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= n_done;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(BW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[BW-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== hdl/wsl_sdiv.sv =====
// ----------------------------------------------------------------------------
// Wheel speed limiter serial scaler
// floor(a * b / c) for b < c, taking the bits of a MSB first.
// ----------------------------------------------------------------------------
module wsl_sdiv #(
    parameter int AW = wsl_pkg::SPEED_WIDTH_DEF,
    parameter int CW = wsl_pkg::SPEED_WIDTH_DEF + wsl_pkg::DIAM_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_a,
    input  logic [CW-1:0] i_b,
    input  logic [CW-1:0] i_c,
    output logic          o_done,
    output logic [AW-1:0] o_quotient
);
    localparam int CNT_W = $clog2(AW);

    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    n_rem;
    logic [AW-1:0]    r_q;
    logic [AW-1:0]    n_q;
    logic [AW-1:0]    r_a;
    logic [CNT_W-1:0] r_cnt;
    logic             r_phase;
    logic             r_busy;
    logic             r_done;
    logic             n_done;
    logic [CW:0]      trial;
    logic [CW+1:0]    diff;
    logic             ge;

    // phase 0 doubles the remainder, phase 1 adds b for a set bit of a;
    // each phase ends with one conditional subtract of c
    always_comb begin
        if (r_phase) begin
            trial = r_a[AW-1] ? ({1'b0, r_rem} + {1'b0, i_b}) : {1'b0, r_rem};
        end else begin
            trial = {r_rem, 1'b0};
        end
        diff  = {1'b0, trial} - {2'b00, i_c};
        ge    = !diff[CW+1];
        n_rem = ge ? diff[CW-1:0] : trial[CW-1:0];
        n_q   = r_phase ? (r_q + AW'(ge)) : {r_q[AW-2:0], ge};
    end

    assign n_done = r_busy && r_phase && (r_cnt == '0) && !i_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= n_done;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= CNT_W'(AW - 1);
            end else if (r_busy) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= '0;
            r_a   <= i_a;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            if (r_phase) begin
                r_a <= {r_a[AW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== hdl/wheel_speed_limiter.sv =====
// ----------------------------------------------------------------------------
// Wheel speed limiter
// Speed and slew-rate limiter for a differential drive, bit-serial datapath.
// Channels: i_cmd takes a transaction of left/right wheel commands and a step
// time; o_spd delivers one transaction of limited left/right speeds for each.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// writes them only while idle, as the block does not enforce it. One
// transaction is in flight at a time and the next one is taken the cycle
// after the result loads. The pace is set by the serial multipliers (wheel
// diameter and step time bits) and, when speed scaling is needed, by the
// serial scaler that runs over the speed magnitude.
// The result sits in an output register: a new command is accepted while the
// result waits; a stalled receiver holds the next result in the slew stage.
// Reset (synchronous, active low) restores the register defaults, clears the
// stored previous speeds to zero and empties the output register.
// ----------------------------------------------------------------------------
`include "wheel_speed_limiter_assert.svh"

module wheel_speed_limiter #(
    parameter int SPEED_WIDTH = wsl_pkg::SPEED_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wsl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wsl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wsl_cmd_if.sink                          i_cmd,
    wsl_spd_if.source                        o_spd
);
    import wsl_pkg::*;

    localparam int W      = SPEED_WIDTH;
    localparam int DW     = W + 1;
    localparam int CW     = W + DIAM_W;
    localparam int CMP_W  = (CW > NUM_W) ? CW : NUM_W;
    localparam int SCMP_W = (DW + TIME_W > BUD_W) ? DW + TIME_W : BUD_W;

    // controller and configuration
    t_state             r_state;
    t_state             n_state;
    logic [DIAM_W-1:0]  r_diam;
    logic [LIMIT_W-1:0] r_maxlin;
    logic [LIMIT_W-1:0] r_maxacc;

    // per-wheel datapath, index 0 is left and 1 is right
    logic [W-1:0]      r_cmd  [2];
    logic [W-1:0]      r_mag  [2];
    logic [W-1:0]      r_tgt  [2];
    logic [W-1:0]      r_prev [2];
    logic [W-1:0]      r_out  [2];
    logic [DW-1:0]     r_dl   [2];
    logic [TIME_W-1:0] r_dt;
    logic              r_out_vld;

    logic [W-1:0]      in_cmd  [2];
    logic [W-1:0]      in_mag  [2];
    logic [W-1:0]      div_q   [2];
    logic              div_done[2];
    logic              dl_neg  [2];
    logic [DW-1:0]     dl_mag  [2];
    logic              over    [2];
    logic [DW-1:0]     prev_x  [2];
    logic [DW-1:0]     sum     [2];
    logic [DW-1:0]     pick    [2];
    logic [W-1:0]      res     [2];

    logic              in_ready;
    logic              mul_start;
    logic              div_start;
    logic              s_load;
    logic              out_free;
    logic              scale;
    logic [W-1:0]      mag_max;
    logic [NUM_W-1:0]  num;
    logic [CW-1:0]     den;
    logic [BUD_W-1:0]  budget;
    logic [DW-1:0]     step;
    logic              den_done;
    logic              bud_done;

    // ------------------------------------------------------------------
    // Input magnitudes, taken at acceptance
    // ------------------------------------------------------------------
    always_comb begin
        in_cmd[0] = i_cmd.left_command;
        in_cmd[1] = i_cmd.right_command;
        for (int k = 0; k < 2; k++) begin
            in_mag[k] = in_cmd[k][W-1] ? (~in_cmd[k] + W'(1)) : in_cmd[k];
        end
    end

    // ------------------------------------------------------------------
    // Serial multipliers: rim speed denominator and slew budget run
    // side by side over 16 bits each
    // ------------------------------------------------------------------
    assign mag_max = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];

    wsl_smul #(
        .AW (W),
        .BW (DIAM_W)
    ) u_den_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mag_max),
        .i_b       (r_diam),
        .o_done    (den_done),
        .o_product (den)
    );

    wsl_smul #(
        .AW (LIMIT_W),
        .BW (TIME_W)
    ) u_bud_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (r_maxacc),
        .i_b       (r_dt),
        .o_done    (bud_done),
        .o_product (budget)
    );

    // scale when the larger rim speed exceeds the limit
    assign num   = {r_maxlin, {NUM_SHIFT{1'b0}}};
    assign scale = CMP_W'(den) > CMP_W'(num);

    // ------------------------------------------------------------------
    // Serial scalers, one per wheel; num < den whenever they run, so it
    // fits the divisor width
    // ------------------------------------------------------------------
    for (genvar g = 0; g < 2; g++) begin : g_lane
        wsl_sdiv #(
            .AW (W),
            .CW (CW)
        ) u_scale (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_a        (r_mag[g]),
            .i_b        (CW'(num)),
            .i_c        (den),
            .o_done     (div_done[g]),
            .o_quotient (div_q[g])
        );
    end

    // ------------------------------------------------------------------
    // Slew limit: allowed step is budget / 2^16; a limited step moves
    // the previous output toward the target by that step
    // ------------------------------------------------------------------
    assign step = DW'(budget[BUD_W-1:TIME_W]);

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            dl_neg[k] = r_dl[k][DW-1];
            dl_mag[k] = dl_neg[k] ? (~r_dl[k] + DW'(1)) : r_dl[k];
            over[k]   = SCMP_W'({dl_mag[k], {TIME_W{1'b0}}}) > SCMP_W'(budget);
            prev_x[k] = {r_prev[k][W-1], r_prev[k]};
            sum[k]    = dl_neg[k] ? (prev_x[k] - step) : (prev_x[k] + step);
            if ((r_dt != '0) && over[k]) begin
                pick[k] = sum[k];
            end else begin
                pick[k] = {r_tgt[k][W-1], r_tgt[k]};
            end
            // saturate to the field range
            if (pick[k][DW-1] != pick[k][DW-2]) begin
                res[k] = pick[k][DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                res[k] = pick[k][W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    assign out_free = !r_out_vld || o_spd.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (den_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = scale ? S_DIV : S_DELTA;
            end
            S_DIV: begin
                if (div_done[0]) begin
                    n_state = S_DELTA;
                end
            end
            S_DELTA: begin
                n_state = S_SLEW;
            end
            S_SLEW: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = (r_state == S_IDLE);
        mul_start = (r_state == S_MAG);
        div_start = (r_state == S_CMP) && scale;
        s_load    = (r_state == S_SLEW) && out_free;
    end

    // control state, configuration and stored previous speeds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_diam    <= DIAM_RST;
            r_maxlin  <= LIMIT_RST;
            r_maxacc  <= ACCEL_RST;
            r_prev[0] <= '0;
            r_prev[1] <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WHEEL_DIAMETER:   r_diam   <= i_cfg_data[DIAM_W-1:0];
                    CFG_MAX_LINEAR_SPEED: r_maxlin <= i_cfg_data[LIMIT_W-1:0];
                    CFG_MAX_ACCELERATION: r_maxacc <= i_cfg_data[LIMIT_W-1:0];
                    default: begin
                        // drop writes to unmapped indexes
                    end
                endcase
            end
            if (s_load) begin
                r_prev[0] <= res[0];
                r_prev[1] <= res[1];
                r_out_vld <= 1'b1;
            end else if (o_spd.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && in_ready) begin
            r_dt <= i_cmd.step_time;
        end
        for (int k = 0; k < 2; k++) begin
            if (i_cmd.valid && in_ready) begin
                r_cmd[k] <= in_cmd[k];
                r_mag[k] <= in_mag[k];
            end
            if ((r_state == S_CMP) && !scale) begin
                r_tgt[k] <= r_cmd[k];
            end
            if ((r_state == S_DIV) && div_done[0]) begin
                // restore the command sign on the scaled magnitude
                r_tgt[k] <= r_cmd[k][W-1] ? (~div_q[k] + W'(1)) : div_q[k];
            end
            if (r_state == S_DELTA) begin
                r_dl[k] <= {r_tgt[k][W-1], r_tgt[k]} - {r_prev[k][W-1], r_prev[k]};
            end
            if (s_load) begin
                r_out[k] <= res[k];
            end
        end
    end

    assign i_cmd.ready       = in_ready;
    assign o_spd.valid       = r_out_vld;
    assign o_spd.left_speed  = r_out[0];
    assign o_spd.right_speed = r_out[1];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `WSL_ASSERT_IMP(a_mul_sync, i_clk, i_rst_n, (r_state == S_MUL) && den_done, bud_done)
    `WSL_ASSERT_IMP(a_div_sync, i_clk, i_rst_n, div_done[0], div_done[1])
    `WSL_ASSERT_IMP(a_div_in_state, i_clk, i_rst_n, div_done[0] || div_done[1], r_state == S_DIV)
    `WSL_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, s_load, !r_out_vld || o_spd.ready)
    `WSL_ASSERT_NXT(a_prev_tracks, i_clk, i_rst_n, s_load, (r_prev[0] == r_out[0]) && (r_prev[1] == r_out[1]))

endmodule
